@@ design/lphs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types and constants for the length-prefixed header splitter.
// ----------------------------------------------------------------------------
package lphs_pkg;

  // Reset value of the maximum header length register
  localparam logic [31:0] LPHS_MAX_LEN_RESET = 32'h0010_0000;

  // Default depth of the result queue (at least 2)
  localparam int unsigned LPHS_FIFO_DEPTH = 4;

  // Input operation codes
  localparam logic LPHS_OP_BYTE = 1'b0;
  localparam logic LPHS_OP_EOS  = 1'b1;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_TAIL = 4'b0100,
    PH_DROP = 4'b1000
  } lphs_phase_e;

  // Result kinds
  typedef enum logic [2:0] {
    K_HDR_BYTE  = 3'd0,
    K_HDR_DONE  = 3'd1,
    K_TAIL_BYTE = 3'd2,
    K_OVERSIZE  = 3'd3,
    K_TRUNC     = 3'd4,
    K_TAIL_END  = 3'd5
  } lphs_kind_e;

  // One result item
  typedef struct packed {
    lphs_kind_e  kind;
    logic [7:0]  value;
    logic [31:0] header_length;
    logic        last;
  } lphs_result_t;

  // Results produced by one input transaction, in order
  typedef struct packed {
    logic [1:0]   count;
    lphs_result_t r0;
    lphs_result_t r1;
  } lphs_push_t;

  function automatic lphs_result_t lphs_mk_result(lphs_kind_e kind, logic [7:0] value,
                                                  logic [31:0] len, logic last);
    lphs_result_t r;
    r.kind          = kind;
    r.value         = value;
    r.header_length = len;
    r.last          = last;
    return r;
  endfunction

endpackage

@@ design/lphs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_in_if / lphs_out_if
// Valid/ready channels for input bytes and result items.
// ----------------------------------------------------------------------------
interface lphs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_value;

  modport source (output valid, op, byte_value, input ready);
  modport sink   (input valid, op, byte_value, output ready);
endinterface

interface lphs_out_if import lphs_pkg::*; ();
  logic        valid;
  logic        ready;
  lphs_kind_e  kind;
  logic [7:0]  value;
  logic [31:0] header_length;
  logic        last;

  modport source (output valid, kind, value, header_length, last, input ready);
  modport sink   (input valid, kind, value, header_length, last, output ready);
endinterface

@@ design/lphs_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_step
// Parser state and per-byte decode: produces up to two results per transaction.
// ----------------------------------------------------------------------------
module lphs_step import lphs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        op_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] max_len_i,
  output lphs_push_t  push_o
);

  lphs_phase_e phase_q, phase_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] cnt_q, cnt_d;

  logic [31:0] shift_in;
  logic [31:0] cnt_inc;

  assign shift_in = {shift_q[23:0], byte_i};
  assign cnt_inc  = cnt_q + 32'd1;

  // Decode of the current transaction
  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    push_o.count = 2'd0;
    push_o.r0    = lphs_mk_result(K_HDR_BYTE, 8'h00, 32'h0, 1'b0);
    push_o.r1    = lphs_mk_result(K_HDR_BYTE, 8'h00, 32'h0, 1'b0);
    if (accept_i) begin
      if (op_i == LPHS_OP_EOS) begin
        phase_d = PH_LEN;
        shift_d = 32'h0;
        cnt_d   = 32'h0;
        unique case (phase_q)
          PH_LEN, PH_HDR: begin
            push_o.count = 2'd1;
            push_o.r0    = lphs_mk_result(K_TRUNC, 8'h00, 32'h0, 1'b1);
          end
          PH_TAIL: begin
            push_o.count = 2'd1;
            push_o.r0    = lphs_mk_result(K_TAIL_END, 8'h00, 32'h0, 1'b1);
          end
          default: ;
        endcase
      end else begin
        unique case (phase_q)
          PH_LEN: begin
            shift_d = shift_in;
            cnt_d   = cnt_inc;
            // fourth prefix byte completes the length
            if (cnt_q[1:0] == 2'd3) begin
              cnt_d = 32'h0;
              if (shift_in > max_len_i) begin
                push_o.count = 2'd1;
                push_o.r0    = lphs_mk_result(K_OVERSIZE, 8'h00, shift_in, 1'b1);
                phase_d      = PH_DROP;
              end else if (shift_in == 32'h0) begin
                push_o.count = 2'd1;
                push_o.r0    = lphs_mk_result(K_HDR_DONE, 8'h00, 32'h0, 1'b1);
                phase_d      = PH_TAIL;
              end else begin
                phase_d = PH_HDR;
              end
            end
          end
          PH_HDR: begin
            if (cnt_inc == shift_q) begin
              // last header byte, then header complete
              push_o.count = 2'd2;
              push_o.r0    = lphs_mk_result(K_HDR_BYTE, byte_i, 32'h0, 1'b0);
              push_o.r1    = lphs_mk_result(K_HDR_DONE, 8'h00, shift_q, 1'b1);
              phase_d      = PH_TAIL;
              cnt_d        = 32'h0;
            end else begin
              push_o.count = 2'd1;
              push_o.r0    = lphs_mk_result(K_HDR_BYTE, byte_i, 32'h0, 1'b1);
              cnt_d        = cnt_inc;
            end
          end
          PH_TAIL: begin
            push_o.count = 2'd1;
            push_o.r0    = lphs_mk_result(K_TAIL_BYTE, byte_i, 32'h0, 1'b1);
          end
          default: ; // discarding after oversize
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      shift_q <= 32'h0;
      cnt_q   <= 32'h0;
    end else begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ design/lphs_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_out_fifo
// Result queue: takes up to two results per cycle, hands out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module lphs_out_fifo import lphs_pkg::*; #(
  parameter int unsigned Depth = LPHS_FIFO_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lphs_push_t   push_i,
  output logic         space2_o,
  output logic         valid_o,
  input  logic         ready_i,
  output lphs_result_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntSpace = CntW'(Depth - 2);

  lphs_result_t          mem_q [Depth];
  logic [PtrW-1:0]       wptr_q, wptr_d, rptr_q, rptr_d, wptr_nx;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  pop;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  assign wptr_nx  = ptr_next(wptr_q);
  assign pop      = valid_o && ready_i;
  assign valid_o  = (cnt_q != '0);
  assign data_o   = mem_q[rptr_q];
  assign space2_o = (cnt_q <= CntSpace);

  // Pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    case (push_i.count)
      2'd1:    wptr_d = wptr_nx;
      2'd2:    wptr_d = ptr_next(wptr_nx);
      default: wptr_d = wptr_q;
    endcase
    rptr_d = pop ? ptr_next(rptr_q) : rptr_q;
    cnt_d  = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_nx] <= push_i.r1;
    end
  end

endmodule

@@ design/length_prefixed_header_splitter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_header_splitter_core
// Splits a byte stream with a 32-bit big-endian length prefix into header
// bytes, a header-complete marker and tail bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one transaction per stream byte (op = 0) or end of stream (op = 1).
//   out_o : result transactions (kind, value, header_length, last); an input
//           causes zero, one or two results, the last one flagged by last.
//   cfg_we_i / cfg_wdata_i : write of max_header_length, only while idle.
// Results are written into the registered result queue and leave it in order.
// Throughput: one input per cycle while in_i.ready is high. The result queue
//   takes up to two results per cycle and drains one; in_i.ready is high
//   while the queue has room for two, so the two-result last header byte is
//   absorbed without a bubble as long as the receiver keeps up.
// Stall: when out_o.ready is low the queue fills and in_i.ready drops; no
//   result is lost or repeated.
// Reset: parser returns to expecting length bytes, queue empties, and
//   max_header_length returns to 0x100000.
// ----------------------------------------------------------------------------
module length_prefixed_header_splitter_core import lphs_pkg::*; #(
  parameter int unsigned FifoDepth = LPHS_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lphs_in_if.sink     in_i,
  lphs_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0]  max_len_q;
  logic         accept;
  logic         space2;
  lphs_push_t   push;
  lphs_result_t head;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= LPHS_MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = space2;
  assign accept     = in_i.valid && space2;

  lphs_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (in_i.op),
    .byte_i    (in_i.byte_value),
    .max_len_i (max_len_q),
    .push_o    (push)
  );

  lphs_out_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .space2_o (space2),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .data_o   (head)
  );

  // Result channel payload
  assign out_o.kind          = head.kind;
  assign out_o.value         = head.value;
  assign out_o.header_length = head.header_length;
  assign out_o.last          = head.last;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for length_prefixed_header_splitter_core. Byte streams
// with big-endian length prefixes are sent with random gaps while the result
// side stalls at random. A cycle-accurate-free stream model predicts every
// result, and each result transaction is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import lphs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned CFG_INTERVAL = 200;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned HDR_SEND_CAP = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  lphs_in_if  in_if ();
  lphs_out_if out_if ();

  length_prefixed_header_splitter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Stream model state
  lphs_phase_e  strm_phase    = PH_LEN;
  logic [31:0]  strm_len      = '0;
  logic [31:0]  strm_count    = '0;
  logic [31:0]  max_hdr_len   = LPHS_MAX_LEN_RESET;
  lphs_result_t pending_results[$];

  int unsigned err_count      = 0;
  int unsigned counted_items  = 0;
  int unsigned cycle_count    = 0;
  bit          no_idle        = 1'b0;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic lphs_result_t shaped_result(lphs_kind_e kind, logic [7:0] value,
                                                 logic [31:0] len);
    lphs_result_t r;
    r.kind          = kind;
    r.value         = value;
    r.header_length = len;
    r.last          = 1'b0;
    return r;
  endfunction

  // Advance the stream model by one transaction; queue its results.
  // Returns 1 when the byte is dropped after an oversize length.
  function automatic bit split_byte(input logic op, input logic [7:0] b);
    lphs_result_t res [2];
    int           n;
    bit           dropped;
    n       = 0;
    dropped = 1'b0;
    if (op == LPHS_OP_EOS) begin
      if (strm_phase == PH_LEN || strm_phase == PH_HDR) begin
        res[n] = shaped_result(K_TRUNC, 8'h00, 32'd0);
        n++;
      end else if (strm_phase == PH_TAIL) begin
        res[n] = shaped_result(K_TAIL_END, 8'h00, 32'd0);
        n++;
      end
      strm_phase = PH_LEN;
      strm_len   = '0;
      strm_count = '0;
    end else begin
      case (strm_phase)
        PH_LEN: begin
          strm_len = {strm_len[23:0], b};
          strm_count++;
          if (strm_count >= 32'd4) begin
            strm_count = '0;
            if (strm_len > max_hdr_len) begin
              res[n] = shaped_result(K_OVERSIZE, 8'h00, strm_len);
              n++;
              strm_phase = PH_DROP;
            end else if (strm_len == 32'd0) begin
              res[n] = shaped_result(K_HDR_DONE, 8'h00, 32'd0);
              n++;
              strm_phase = PH_TAIL;
            end else begin
              strm_phase = PH_HDR;
            end
          end
        end
        PH_HDR: begin
          res[n] = shaped_result(K_HDR_BYTE, b, 32'd0);
          n++;
          strm_count++;
          if (strm_count >= strm_len) begin
            res[n] = shaped_result(K_HDR_DONE, 8'h00, strm_len);
            n++;
            strm_phase = PH_TAIL;
            strm_count = '0;
          end
        end
        PH_TAIL: begin
          res[n] = shaped_result(K_TAIL_BYTE, b, 32'd0);
          n++;
        end
        default: dropped = 1'b1;
      endcase
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
    return dropped;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    lphs_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result: kind %0d value %02h len %08h last %0b",
                             out_if.kind, out_if.value, out_if.header_length, out_if.last));
      end else begin
        want = pending_results.pop_front();
        if (out_if.kind !== want.kind || out_if.value !== want.value ||
            out_if.header_length !== want.header_length || out_if.last !== want.last) begin
          flag_error($sformatf({"result mismatch: expected kind %0d value %02h len %08h ",
                                "last %0b, got kind %0d value %02h len %08h last %0b"},
                               want.kind, want.value, want.header_length, want.last,
                               out_if.kind, out_if.value, out_if.header_length,
                               out_if.last));
        end
      end
    end
  end

  // Receiver backpressure: random stalls, mostly short
  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    forever begin
      gap = pick_gap();
      if (gap != 0) begin
        out_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  end

  // Send one transaction; entered and left at a falling edge
  task automatic send_item(input logic op, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.op         = op;
    in_if.byte_value = b;
    in_if.valid      = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    if (!split_byte(op, b)) counted_items++;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic send_length(input logic [31:0] len);
    for (int i = 3; i >= 0; i--) send_item(LPHS_OP_BYTE, len[8*i +: 8]);
  endtask

  // Wait for all results, then let the pipeline settle
  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_max_len(input logic [31:0] v);
    wait_drained();
    cfg_wdata_i = v;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    max_hdr_len = v;
  endtask

  // Length choice biased toward the limit, empty headers and short headers
  function automatic logic [31:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return max_hdr_len;
    if (r < 20) return (max_hdr_len != '1) ? max_hdr_len + 32'd1 : 32'($urandom);
    if (r < 28) return 32'($urandom);
    if (r < 35) return 32'd0;
    if (r < 37 && max_hdr_len >= HDR_SEND_CAP) return $urandom_range(64, HDR_SEND_CAP);
    if (max_hdr_len < 16) return $urandom_range(0, max_hdr_len);
    return $urandom_range(1, 12);
  endfunction

  function automatic logic [31:0] pick_max_len();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return LPHS_MAX_LEN_RESET;
      3:       return $urandom_range(1, 40);
      4:       return 32'($urandom);
      default: return $urandom_range(2, 16);
    endcase
  endfunction

  // One stream: mostly well formed, some cut short, some noise
  task automatic send_stream();
    int unsigned r;
    int unsigned n_hdr;
    logic [31:0] len;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      len = pick_length();
      send_length(len);
      if (len > max_hdr_len) begin
        repeat ($urandom_range(0, 4)) send_item(LPHS_OP_BYTE, 8'($urandom));
      end else begin
        n_hdr = (len <= HDR_SEND_CAP) ? len : $urandom_range(0, 20);
        if (len != 0 && $urandom_range(0, 7) == 0)
          n_hdr = $urandom_range(0, (len - 32'd1 < 32'd20) ? len - 32'd1 : 32'd20);
        repeat (n_hdr) send_item(LPHS_OP_BYTE, 8'($urandom));
        if (n_hdr == len)
          repeat ($urandom_range(0, 6)) send_item(LPHS_OP_BYTE, 8'($urandom));
      end
      send_item(LPHS_OP_EOS, 8'($urandom));
    end else if (r < 90) begin
      // end of stream inside the length prefix
      repeat ($urandom_range(0, 3)) send_item(LPHS_OP_BYTE, 8'($urandom));
      send_item(LPHS_OP_EOS, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8))
        send_item(($urandom_range(0, 3) == 0) ? LPHS_OP_EOS : LPHS_OP_BYTE, 8'($urandom));
    end
  endtask

  // Special cases at the reset limit
  task automatic test_directed();
    send_item(LPHS_OP_EOS, 8'h00);               // no length bytes at all
    send_length(32'd0);                          // empty header
    send_item(LPHS_OP_BYTE, 8'hFF);
    send_item(LPHS_OP_EOS, 8'h00);
    send_length(32'd1);                          // last header byte gives two results
    send_item(LPHS_OP_BYTE, 8'hAA);
    send_item(LPHS_OP_EOS, 8'hFF);
    send_length(LPHS_MAX_LEN_RESET + 32'd1);     // oversize, then dropped bytes
    send_item(LPHS_OP_BYTE, 8'h55);
    send_item(LPHS_OP_EOS, 8'h00);
    send_length(LPHS_MAX_LEN_RESET);             // equal to limit, then truncated
    send_item(LPHS_OP_EOS, 8'h00);
  endtask

  // Limit register at its extremes
  task automatic test_limit_extremes();
    write_max_len(32'd0);
    send_length(32'd0);
    send_item(LPHS_OP_BYTE, 8'h01);
    send_item(LPHS_OP_EOS, 8'h00);
    send_length(32'd1);
    send_item(LPHS_OP_EOS, 8'h00);
    write_max_len(32'hFFFF_FFFF);
    send_length(32'hFFFF_FFFF);
    repeat (3) send_item(LPHS_OP_BYTE, 8'($urandom));
    send_item(LPHS_OP_EOS, 8'h00);
    write_max_len(32'd1);
    send_length(32'd1);
    send_item(LPHS_OP_BYTE, 8'h80);
    send_item(LPHS_OP_BYTE, 8'h7F);
    send_item(LPHS_OP_EOS, 8'h00);
    send_length(32'd2);
    send_item(LPHS_OP_EOS, 8'h00);
    write_max_len(LPHS_MAX_LEN_RESET);
  endtask

  // Random streams with the limit changed now and then
  task automatic test_random_streams();
    int unsigned next_cfg;
    counted_items = 0;
    next_cfg      = CFG_INTERVAL;
    while (counted_items < RANDOM_ITEMS) begin
      if (counted_items >= next_cfg) begin
        no_idle = 1'b0;
        write_max_len(pick_max_len());
        next_cfg = counted_items + CFG_INTERVAL;
      end
      no_idle = ($urandom_range(0, 9) == 0);
      send_stream();
    end
    no_idle = 1'b0;
  endtask

  // Main sequence
  initial begin
    in_if.valid      = 1'b0;
    in_if.op         = LPHS_OP_BYTE;
    in_if.byte_value = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_limit_extremes();
    test_random_streams();

    wait_drained();
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
